/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the alert conditioner RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PDAC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Condition that must never be true outside reset.
`define PDAC_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

/* rtl/pdac_pkg.sv */
// ---------------------------------------------------------------------------
// pdac_pkg
// Types, constants and helper functions of the posture/distance alert
// conditioner.
// ---------------------------------------------------------------------------
package pdac_pkg;

  // Field widths
  localparam int unsigned TsW      = 32;
  localparam int unsigned TiltW    = 11;
  localparam int unsigned RangeW   = 12;
  localparam int unsigned LightW   = 10;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned HzW      = 11;
  localparam int unsigned SevW     = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TILT_WARN     = 3'd0,
    REG_TILT_CRITICAL = 3'd1,
    REG_NEAR_WARN     = 3'd2,
    REG_NEAR_CRITICAL = 3'd3,
    REG_TILT_HOLD     = 3'd4,
    REG_NEAR_HOLD     = 3'd5,
    REG_SETTLE        = 3'd6
  } cfg_reg_e;

  // Register reset values
  localparam logic [TiltW-1:0]  TILT_WARN_RST     = 11'd200;
  localparam logic [TiltW-1:0]  TILT_CRITICAL_RST = 11'd350;
  localparam logic [RangeW-1:0] NEAR_WARN_RST     = 12'd400;
  localparam logic [RangeW-1:0] NEAR_CRITICAL_RST = 12'd250;
  localparam logic [HoldW-1:0]  TILT_HOLD_RST     = 16'd3000;
  localparam logic [HoldW-1:0]  NEAR_HOLD_RST     = 16'd3000;
  localparam logic [HoldW-1:0]  SETTLE_RST        = 16'd500;

  // Severity breakpoints with a single alert up
  localparam logic [TiltW-1:0]  TILT_SEV3 = 11'd500;
  localparam logic [TiltW-1:0]  TILT_SEV2 = 11'd350;
  localparam logic [RangeW-1:0] NEAR_SEV3 = 12'd50;
  localparam logic [RangeW-1:0] NEAR_SEV2 = 12'd100;

  // Buzzer tempos in ms
  localparam logic [TsW-1:0] FAST_OFF_MS  = 32'd250;
  localparam logic [TsW-1:0] FAST_ON_MS   = 32'd120;
  localparam logic [TsW-1:0] MED_OFF_MS   = 32'd700;
  localparam logic [TsW-1:0] SHORT_ON_MS  = 32'd90;
  localparam logic [TsW-1:0] SLOW_OFF_MS  = 32'd900;

  // Brightness map
  localparam logic [LightW:0]   LIGHT_MAX = 11'd1023;
  localparam logic [LevelW-1:0] LEVEL_MIN = 8'd15;

  // Severity codes
  typedef enum logic [SevW-1:0] {
    SEV_NONE   = 2'd0,
    SEV_GREEN  = 2'd1,
    SEV_BLUE   = 2'd2,
    SEV_YELLOW = 2'd3
  } sev_e;

  // Tone codes
  typedef enum logic [1:0] {
    TONE_NONE   = 2'd0,
    TONE_FAST   = 2'd1,
    TONE_MEDIUM = 2'd2,
    TONE_SLOW   = 2'd3
  } tone_e;

  typedef struct packed {
    logic [TiltW-1:0]  tilt_warn;
    logic [TiltW-1:0]  tilt_critical;
    logic [RangeW-1:0] near_warn;
    logic [RangeW-1:0] near_critical;
    logic [HoldW-1:0]  tilt_hold_ms;
    logic [HoldW-1:0]  near_hold_ms;
    logic [HoldW-1:0]  settle_ms;
  } cfg_t;

  typedef struct packed {
    logic near_crit;
    logic tilt_crit;
    logic near;
    logic tilt;
  } alert_flags_t;

  // Tone frequency of a code
  function automatic logic [HzW-1:0] tone_freq(tone_e code);
    logic [HzW-1:0] hz;
    unique case (code)
      TONE_FAST:   hz = 11'd1600;
      TONE_MEDIUM: hz = 11'd1100;
      TONE_SLOW:   hz = 11'd900;
      default:     hz = '0;
    endcase
    return hz;
  endfunction

  // light * 240 / 1023 + 15, truncated. Quotient by 1023: take x >> 10,
  // the remainder is then (x & 1023) + q0 < 2 * 1023, one correction step.
  function automatic logic [LevelW-1:0] light_level(logic [LightW-1:0] light);
    logic [17:0]       prod;
    logic [LevelW-1:0] q0;
    logic [LightW:0]   rem;
    logic [LevelW-1:0] q;
    prod = {light, 8'd0} - {4'd0, light, 4'd0};
    q0   = prod[17:10];
    rem  = {1'b0, prod[9:0]} + {3'd0, q0};
    q    = (rem >= LIGHT_MAX) ? q0 + 8'd1 : q0;
    return q + LEVEL_MIN;
  endfunction

endpackage

/* rtl/posture_distance_alert_conditioner.sv */
// ---------------------------------------------------------------------------
// posture_distance_alert_conditioner
// Turns timestamped tilt/distance/light samples into held alerts, a settled
// severity with LED levels and a buzzer pattern.
// ---------------------------------------------------------------------------
// One sample beat in, one result beat out. A sample sits in the input
// register while the alert, severity and buzzer logic update their state,
// and the result is registered. A new sample is accepted every cycle as
// long as the output side takes results. All timing is by the sample
// timestamps, not by the clock. Register writes on the config port are
// taken at any time (ready is always high) and are meant to happen while
// no sample is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module posture_distance_alert_conditioner (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pdac_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pdac_pkg::CfgDataW-1:0]   cfg_data_i,
  // Sample channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [pdac_pkg::TsW-1:0]        timestamp_ms_i,
  input  logic [pdac_pkg::TiltW-1:0]      tilt_tenths_i,
  input  logic [pdac_pkg::RangeW-1:0]     range_tenths_i,
  input  logic                            range_ok_i,
  input  logic [pdac_pkg::LightW-1:0]     light_raw_i,
  input  logic                            clear_alerts_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            tilt_alert_o,
  output logic                            near_alert_o,
  output logic                            tilt_crit_flag_o,
  output logic                            near_crit_flag_o,
  output logic [pdac_pkg::SevW-1:0]       shown_severity_o,
  output logic [pdac_pkg::LevelW-1:0]     green_level_o,
  output logic [pdac_pkg::LevelW-1:0]     blue_level_o,
  output logic [pdac_pkg::LevelW-1:0]     yellow_level_o,
  output logic                            buzzer_sound_o,
  output logic [pdac_pkg::HzW-1:0]        tone_hz_o
);
  import pdac_pkg::*;

  // Config registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tilt_warn     <= TILT_WARN_RST;
      cfg_q.tilt_critical <= TILT_CRITICAL_RST;
      cfg_q.near_warn     <= NEAR_WARN_RST;
      cfg_q.near_critical <= NEAR_CRITICAL_RST;
      cfg_q.tilt_hold_ms  <= TILT_HOLD_RST;
      cfg_q.near_hold_ms  <= NEAR_HOLD_RST;
      cfg_q.settle_ms     <= SETTLE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TILT_WARN:     cfg_q.tilt_warn     <= cfg_data_i[TiltW-1:0];
        REG_TILT_CRITICAL: cfg_q.tilt_critical <= cfg_data_i[TiltW-1:0];
        REG_NEAR_WARN:     cfg_q.near_warn     <= cfg_data_i[RangeW-1:0];
        REG_NEAR_CRITICAL: cfg_q.near_critical <= cfg_data_i[RangeW-1:0];
        REG_TILT_HOLD:     cfg_q.tilt_hold_ms  <= cfg_data_i[HoldW-1:0];
        REG_NEAR_HOLD:     cfg_q.near_hold_ms  <= cfg_data_i[HoldW-1:0];
        REG_SETTLE:        cfg_q.settle_ms     <= cfg_data_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Input stage handshake
  logic               s1_valid_q;
  logic [TsW-1:0]     s1_now_q;
  logic [TiltW-1:0]   s1_tilt_q;
  logic [RangeW-1:0]  s1_range_q;
  logic               s1_ok_q;
  logic [LightW-1:0]  s1_light_q;
  logic               s1_clear_q;
  logic               advance, in_take;
  logic               out_valid_q;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_now_q   <= timestamp_ms_i;
      s1_tilt_q  <= tilt_tenths_i;
      s1_range_q <= range_tenths_i;
      s1_ok_q    <= range_ok_i;
      s1_light_q <= light_raw_i;
      s1_clear_q <= clear_alerts_i;
    end
  end

  // Compute stage
  alert_flags_t       flags;
  logic [SevW-1:0]    shown;
  logic [LevelW-1:0]  green, blue, yellow;
  logic               sound;
  logic [HzW-1:0]     hz;

  pdac_alert u_alert (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .now_i      (s1_now_q),
    .tilt_i     (s1_tilt_q),
    .range_i    (s1_range_q),
    .range_ok_i (s1_ok_q),
    .clear_i    (s1_clear_q),
    .cfg_i      (cfg_q),
    .flags_o    (flags)
  );

  pdac_sev u_sev (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .now_i       (s1_now_q),
    .tilt_i      (s1_tilt_q),
    .range_i     (s1_range_q),
    .light_i     (s1_light_q),
    .settle_ms_i (cfg_q.settle_ms),
    .flags_i     (flags),
    .shown_o     (shown),
    .green_o     (green),
    .blue_o      (blue),
    .yellow_o    (yellow)
  );

  pdac_buzz u_buzz (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .now_i     (s1_now_q),
    .clear_i   (s1_clear_q),
    .flags_i   (flags),
    .sound_o   (sound),
    .tone_hz_o (hz)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tilt_alert_o     <= flags.tilt;
      near_alert_o     <= flags.near;
      tilt_crit_flag_o <= flags.tilt_crit;
      near_crit_flag_o <= flags.near_crit;
      shown_severity_o <= shown;
      green_level_o    <= green;
      blue_level_o     <= blue;
      yellow_level_o   <= yellow;
      buzzer_sound_o   <= sound;
      tone_hz_o        <= hz;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  `PDAC_NEVER(a_stall_without_item, clk_i, rst_ni, in_stall_o && !s1_valid_q)
  `PDAC_ASSERT(a_full_blocked_stalls, clk_i, rst_ni,
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
  `PDAC_ASSERT(a_tone_matches_sound, clk_i, rst_ni,
    out_valid_q |-> ((tone_hz_o != '0) == buzzer_sound_o))
  `PDAC_ASSERT(a_one_led_lit, clk_i, rst_ni,
    out_valid_q |-> ($countones({green_level_o != '0, blue_level_o != '0,
                                 yellow_level_o != '0}) <= 1))
  `PDAC_ASSERT(a_dark_when_none, clk_i, rst_ni,
    (out_valid_q && (shown_severity_o == SEV_NONE)) |->
      ((green_level_o == '0) && (blue_level_o == '0) && (yellow_level_o == '0)))

endmodule

/* rtl/pdac_alert.sv */
// ---------------------------------------------------------------------------
// pdac_alert
// Threshold compare and hold timers for the posture and distance alerts.
// ---------------------------------------------------------------------------
module pdac_alert (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [pdac_pkg::TsW-1:0]     now_i,
  input  logic [pdac_pkg::TiltW-1:0]   tilt_i,
  input  logic [pdac_pkg::RangeW-1:0]  range_i,
  input  logic                         range_ok_i,
  input  logic                         clear_i,
  input  pdac_pkg::cfg_t               cfg_i,
  output pdac_pkg::alert_flags_t       flags_o
);
  import pdac_pkg::*;

  logic               tilt_run_q, tilt_run_d;
  logic [TsW-1:0]     tilt_start_q, tilt_start_d;
  logic               near_run_q, near_run_d;
  logic [TsW-1:0]     near_start_q, near_start_d;
  alert_flags_t       flags_q, flags_d;

  logic               t_now, n_now;
  logic               tilt_run_eff, near_run_eff;
  logic [TsW-1:0]     tilt_from, near_from;
  logic [TsW-1:0]     tilt_elapsed, near_elapsed;
  alert_flags_t       flags_old;

  // Clear request acts before the sample is evaluated
  assign tilt_run_eff = tilt_run_q & ~clear_i;
  assign near_run_eff = near_run_q & ~clear_i;
  assign flags_old    = clear_i ? '0 : flags_q;

  assign t_now = (tilt_i >= cfg_i.tilt_warn);
  assign n_now = range_ok_i && (range_i <= cfg_i.near_warn);

  // A timer that is not running starts at this sample
  assign tilt_from    = tilt_run_eff ? tilt_start_q : now_i;
  assign near_from    = near_run_eff ? near_start_q : now_i;
  assign tilt_elapsed = now_i - tilt_from;
  assign near_elapsed = now_i - near_from;

  // Next timer state and alert flags
  always_comb begin
    flags_d           = '0;
    flags_d.tilt      = flags_old.tilt;
    flags_d.near      = flags_old.near;
    flags_d.tilt_crit = (tilt_i >= cfg_i.tilt_critical);
    flags_d.near_crit = range_ok_i && (range_i <= cfg_i.near_critical);
    tilt_run_d        = 1'b0;
    tilt_start_d      = '0;
    near_run_d        = 1'b0;
    near_start_d      = '0;
    if (t_now) begin
      tilt_run_d   = 1'b1;
      tilt_start_d = tilt_from;
      if (tilt_elapsed >= {16'd0, cfg_i.tilt_hold_ms}) begin
        flags_d.tilt = 1'b1;
      end
    end else begin
      flags_d.tilt      = 1'b0;
      flags_d.tilt_crit = 1'b0;
    end
    if (n_now) begin
      near_run_d   = 1'b1;
      near_start_d = near_from;
      if (near_elapsed >= {16'd0, cfg_i.near_hold_ms}) begin
        flags_d.near = 1'b1;
      end
    end else begin
      flags_d.near      = 1'b0;
      flags_d.near_crit = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_run_q   <= 1'b0;
      tilt_start_q <= '0;
      near_run_q   <= 1'b0;
      near_start_q <= '0;
      flags_q      <= '0;
    end else if (en_i) begin
      tilt_run_q   <= tilt_run_d;
      tilt_start_q <= tilt_start_d;
      near_run_q   <= near_run_d;
      near_start_q <= near_start_d;
      flags_q      <= flags_d;
    end
  end

  assign flags_o = flags_d;

endmodule

/* rtl/pdac_sev.sv */
// ---------------------------------------------------------------------------
// pdac_sev
// Severity derivation, settle filter and LED brightness.
// ---------------------------------------------------------------------------
module pdac_sev (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [pdac_pkg::TsW-1:0]     now_i,
  input  logic [pdac_pkg::TiltW-1:0]   tilt_i,
  input  logic [pdac_pkg::RangeW-1:0]  range_i,
  input  logic [pdac_pkg::LightW-1:0]  light_i,
  input  logic [pdac_pkg::HoldW-1:0]   settle_ms_i,
  input  pdac_pkg::alert_flags_t       flags_i,
  output logic [pdac_pkg::SevW-1:0]    shown_o,
  output logic [pdac_pkg::LevelW-1:0]  green_o,
  output logic [pdac_pkg::LevelW-1:0]  blue_o,
  output logic [pdac_pkg::LevelW-1:0]  yellow_o
);
  import pdac_pkg::*;

  sev_e              cur_q, cur_d;
  sev_e              pend_q, pend_d;
  logic [TsW-1:0]    since_q, since_d;
  sev_e              sev;
  logic [TsW-1:0]    pend_age;
  logic [LevelW-1:0] level;

  // Raw severity from the updated alerts
  always_comb begin
    priority if (!flags_i.tilt && !flags_i.near) begin
      sev = SEV_NONE;
    end else if (flags_i.tilt && flags_i.near) begin
      sev = SEV_YELLOW;
    end else if (flags_i.tilt) begin
      priority if (tilt_i >= TILT_SEV3) sev = SEV_YELLOW;
      else if (tilt_i >= TILT_SEV2) sev = SEV_BLUE;
      else sev = SEV_GREEN;
    end else begin
      priority if (range_i <= NEAR_SEV3) sev = SEV_YELLOW;
      else if (range_i <= NEAR_SEV2) sev = SEV_BLUE;
      else sev = SEV_GREEN;
    end
  end

  assign pend_age = now_i - since_q;

  // Settle filter
  always_comb begin
    cur_d   = cur_q;
    pend_d  = pend_q;
    since_d = since_q;
    if (sev != cur_q) begin
      if (sev != pend_q) begin
        pend_d  = sev;
        since_d = now_i;
      end else if (pend_age >= {16'd0, settle_ms_i}) begin
        cur_d = pend_q;
      end
    end else begin
      pend_d  = cur_q;
      since_d = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= SEV_NONE;
      pend_q  <= SEV_NONE;
      since_q <= '0;
    end else if (en_i) begin
      cur_q   <= cur_d;
      pend_q  <= pend_d;
      since_q <= since_d;
    end
  end

  // At most one LED lit, at the ambient-scaled level
  assign level    = light_level(light_i);
  assign shown_o  = cur_d;
  assign green_o  = (cur_d == SEV_GREEN)  ? level : '0;
  assign blue_o   = (cur_d == SEV_BLUE)   ? level : '0;
  assign yellow_o = (cur_d == SEV_YELLOW) ? level : '0;

endmodule

/* rtl/pdac_buzz.sv */
// ---------------------------------------------------------------------------
// pdac_buzz
// Non-blocking buzzer on/off pattern with three tempos.
// ---------------------------------------------------------------------------
module pdac_buzz (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [pdac_pkg::TsW-1:0]   now_i,
  input  logic                       clear_i,
  input  pdac_pkg::alert_flags_t     flags_i,
  output logic                       sound_o,
  output logic [pdac_pkg::HzW-1:0]   tone_hz_o
);
  import pdac_pkg::*;

  logic           beep_q, beep_d;
  logic [TsW-1:0] mark_q, mark_d;
  tone_e          tone_q, tone_d;

  logic           beep_eff;
  tone_e          tone_eff;
  logic           any_alert, fast, near_tempo;
  logic [TsW-1:0] off_ms, on_ms;
  tone_e          code;
  logic [TsW-1:0] elapsed;

  assign beep_eff   = beep_q & ~clear_i;
  assign tone_eff   = clear_i ? TONE_NONE : tone_q;
  assign any_alert  = flags_i.tilt | flags_i.near;
  assign fast       = (flags_i.tilt & flags_i.near) | flags_i.tilt_crit | flags_i.near_crit;
  assign near_tempo = flags_i.near;
  assign elapsed    = now_i - mark_q;

  // Tempo selection
  always_comb begin
    priority if (fast) begin
      off_ms = FAST_OFF_MS;
      on_ms  = FAST_ON_MS;
      code   = TONE_FAST;
    end else if (near_tempo) begin
      off_ms = MED_OFF_MS;
      on_ms  = SHORT_ON_MS;
      code   = TONE_MEDIUM;
    end else begin
      off_ms = SLOW_OFF_MS;
      on_ms  = SHORT_ON_MS;
      code   = TONE_SLOW;
    end
  end

  // Pattern step; a sounding tone keeps its code until it stops
  always_comb begin
    beep_d = beep_eff;
    tone_d = tone_eff;
    mark_d = mark_q;
    if (!any_alert) begin
      beep_d = 1'b0;
      tone_d = TONE_NONE;
    end else if (!beep_eff && (elapsed >= off_ms)) begin
      beep_d = 1'b1;
      tone_d = code;
      mark_d = now_i;
    end else if (beep_eff && (elapsed >= on_ms)) begin
      beep_d = 1'b0;
      mark_d = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beep_q <= 1'b0;
      mark_q <= '0;
      tone_q <= TONE_NONE;
    end else if (en_i) begin
      beep_q <= beep_d;
      mark_q <= mark_d;
      tone_q <= tone_d;
    end
  end

  assign sound_o   = beep_d;
  assign tone_hz_o = beep_d ? tone_freq(tone_d) : '0;

endmodule

/* bench/posture_distance_alert_conditioner_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// posture_distance_alert_conditioner_test
// Self-checking bench for the alert conditioner. Timestamped samples are
// sent with random gaps while the result side stalls in random bursts. A
// scoreboard mirrors the alert timers, severity settling, LED levels and
// buzzer tempo, and checks every result beat field by field against it.
// ---------------------------------------------------------------------------
module posture_distance_alert_conditioner_test;
  import pdac_pkg::*;

  localparam int unsigned IdleLimit = 5000;  // cycles with no beat at all
  localparam int unsigned LongHold  = 60;    // output hold that fills the pipe
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  // Severity breakpoints and buzzer timing, in tenths and ms
  localparam int unsigned SevTilt3 = 500;
  localparam int unsigned SevTilt2 = 350;
  localparam int unsigned SevNear3 = 50;
  localparam int unsigned SevNear2 = 100;
  localparam int unsigned FastOff  = 250;
  localparam int unsigned FastOn   = 120;
  localparam int unsigned MedOff   = 700;
  localparam int unsigned ShortOn  = 90;
  localparam int unsigned SlowOff  = 900;

  typedef struct packed {
    logic              tilt_alert;
    logic              near_alert;
    logic              tilt_crit;
    logic              near_crit;
    logic [SevW-1:0]   severity;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
    logic [LevelW-1:0] yellow;
    logic              sound;
    logic [HzW-1:0]    hz;
  } readout_t;

  // Expected behavior of the conditioner and the check of its result beats
  class alert_scoreboard;
    logic [TiltW-1:0]  tilt_warn, tilt_crit;
    logic [RangeW-1:0] near_warn, near_crit;
    logic [HoldW-1:0]  tilt_hold, near_hold, settle;
    bit                tilt_running, near_running, beeping;
    logic [TsW-1:0]    tilt_start, near_start, pending_since, beep_mark;
    alert_flags_t      flags;
    sev_e              shown_sev, pending_sev;
    tone_e             tone;
    readout_t          due_readouts[$];
    int unsigned       errors, checked;

    function new();
      tilt_warn = 200;  tilt_crit = 350;
      near_warn = 400;  near_crit = 250;
      tilt_hold = 3000; near_hold = 3000; settle = 500;
      tilt_running = 0; near_running = 0; beeping = 0;
      tilt_start = '0; near_start = '0; pending_since = '0; beep_mark = '0;
      flags = '0;
      shown_sev = SEV_NONE; pending_sev = SEV_NONE;
      tone = TONE_NONE;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_TILT_WARN:     tilt_warn = data[TiltW-1:0];
        REG_TILT_CRITICAL: tilt_crit = data[TiltW-1:0];
        REG_NEAR_WARN:     near_warn = data[RangeW-1:0];
        REG_NEAR_CRITICAL: near_crit = data[RangeW-1:0];
        REG_TILT_HOLD:     tilt_hold = data;
        REG_NEAR_HOLD:     near_hold = data;
        REG_SETTLE:        settle = data;
        default: ;
      endcase
    endfunction

    // One step of the on/off pattern at the given tempo
    function void beep_step(logic [TsW-1:0] now, int unsigned off_ms, int unsigned on_ms,
                            tone_e code);
      logic [TsW-1:0] since;
      since = now - beep_mark;
      if (!beeping && since >= off_ms) begin
        beeping = 1;
        tone = code;
        beep_mark = now;
      end else if (beeping && since >= on_ms) begin
        beeping = 0;
        beep_mark = now;
      end
    endfunction

    function void note_sample(logic [TsW-1:0] now, logic [TiltW-1:0] tilt,
                              logic [RangeW-1:0] range, logic ok,
                              logic [LightW-1:0] light, logic clr);
      alert_flags_t   nf;
      logic           t_now, n_now;
      logic [TsW-1:0] since;
      sev_e           sev;
      int unsigned    lvl;
      readout_t       r;
      // clear request drops timers, alerts and buzzer, then the sample runs
      if (clr) begin
        tilt_running = 0; near_running = 0;
        tilt_start = '0; near_start = '0;
        flags = '0;
        beeping = 0; tone = TONE_NONE;
      end

      // hold timers and alert flags
      t_now = (tilt >= tilt_warn);
      n_now = ok && (range <= near_warn);
      nf = '0;
      nf.tilt = flags.tilt;
      nf.near = flags.near;
      nf.tilt_crit = (tilt >= tilt_crit);
      nf.near_crit = ok && (range <= near_crit);
      if (t_now) begin
        if (!tilt_running) begin
          tilt_running = 1;
          tilt_start = now;
        end
        since = now - tilt_start;
        if (since >= tilt_hold) nf.tilt = 1;
      end else begin
        tilt_running = 0; tilt_start = '0;
        nf.tilt = 0; nf.tilt_crit = 0;
      end
      if (n_now) begin
        if (!near_running) begin
          near_running = 1;
          near_start = now;
        end
        since = now - near_start;
        if (since >= near_hold) nf.near = 1;
      end else begin
        near_running = 0; near_start = '0;
        nf.near = 0; nf.near_crit = 0;
      end
      flags = nf;

      // raw severity from the held alerts
      if (!flags.tilt && !flags.near) sev = SEV_NONE;
      else if (flags.tilt && flags.near) sev = SEV_YELLOW;
      else if (flags.tilt) begin
        if (tilt >= SevTilt3) sev = SEV_YELLOW;
        else if (tilt >= SevTilt2) sev = SEV_BLUE;
        else sev = SEV_GREEN;
      end else begin
        if (range <= SevNear3) sev = SEV_YELLOW;
        else if (range <= SevNear2) sev = SEV_BLUE;
        else sev = SEV_GREEN;
      end

      // settling: a new severity must persist before it is shown
      if (sev != shown_sev) begin
        if (sev != pending_sev) begin
          pending_sev = sev;
          pending_since = now;
        end else begin
          since = now - pending_since;
          if (since >= settle) shown_sev = pending_sev;
        end
      end else begin
        pending_sev = shown_sev;
        pending_since = now;
      end
      lvl = int'(light) * 240 / 1023 + 15;

      // buzzer tempo
      if (!flags.tilt && !flags.near) begin
        beeping = 0;
        tone = TONE_NONE;
      end else if ((flags.tilt && flags.near) || flags.tilt_crit || flags.near_crit)
        beep_step(now, FastOff, FastOn, TONE_FAST);
      else if (flags.near)
        beep_step(now, MedOff, ShortOn, TONE_MEDIUM);
      else
        beep_step(now, SlowOff, ShortOn, TONE_SLOW);

      r.tilt_alert = flags.tilt;
      r.near_alert = flags.near;
      r.tilt_crit  = flags.tilt_crit;
      r.near_crit  = flags.near_crit;
      r.severity   = shown_sev;
      r.green      = (shown_sev == SEV_GREEN)  ? 8'(lvl) : 8'd0;
      r.blue       = (shown_sev == SEV_BLUE)   ? 8'(lvl) : 8'd0;
      r.yellow     = (shown_sev == SEV_YELLOW) ? 8'(lvl) : 8'd0;
      r.sound      = beeping;
      r.hz         = '0;
      if (beeping) begin
        case (tone)
          TONE_FAST:   r.hz = 11'd1600;
          TONE_MEDIUM: r.hz = 11'd1100;
          TONE_SLOW:   r.hz = 11'd900;
          default:     r.hz = '0;
        endcase
      end
      due_readouts.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_readout(readout_t got);
      readout_t want;
      if (due_readouts.size() == 0) begin
        errors++;
        $display("%0t: result beat with no sample outstanding", $time);
        return;
      end
      want = due_readouts.pop_front();
      checked++;
      compare_field("tilt_alert", 32'(want.tilt_alert), 32'(got.tilt_alert));
      compare_field("near_alert", 32'(want.near_alert), 32'(got.near_alert));
      compare_field("tilt_crit_flag", 32'(want.tilt_crit), 32'(got.tilt_crit));
      compare_field("near_crit_flag", 32'(want.near_crit), 32'(got.near_crit));
      compare_field("shown_severity", 32'(want.severity), 32'(got.severity));
      compare_field("green_level", 32'(want.green), 32'(got.green));
      compare_field("blue_level", 32'(want.blue), 32'(got.blue));
      compare_field("yellow_level", 32'(want.yellow), 32'(got.yellow));
      compare_field("buzzer_sound", 32'(want.sound), 32'(got.sound));
      compare_field("tone_hz", 32'(want.hz), 32'(got.hz));
    endfunction
  endclass

  // DUT signals; the inputs are known from time zero
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [TsW-1:0]      timestamp_ms_i = '0;
  logic [TiltW-1:0]    tilt_tenths_i  = '0;
  logic [RangeW-1:0]   range_tenths_i = '0;
  logic                range_ok_i     = 1'b0;
  logic [LightW-1:0]   light_raw_i    = '0;
  logic                clear_alerts_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic                tilt_alert_o, near_alert_o, tilt_crit_flag_o, near_crit_flag_o;
  logic [SevW-1:0]     shown_severity_o;
  logic [LevelW-1:0]   green_level_o, blue_level_o, yellow_level_o;
  logic                buzzer_sound_o;
  logic [HzW-1:0]      tone_hz_o;
  readout_t            seen_readout;

  alert_scoreboard sb;
  logic [TsW-1:0]  clock_ms;
  int unsigned     idle_cycles = 0;
  int unsigned     n_settings = 0;
  int unsigned     stall_left = 0, free_left = 0, hold_left = 0;
  bit              stall_on = 1'b1, gaps_on = 1'b1, hold_request = 1'b0;

  posture_distance_alert_conditioner uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .timestamp_ms_i   (timestamp_ms_i),
    .tilt_tenths_i    (tilt_tenths_i),
    .range_tenths_i   (range_tenths_i),
    .range_ok_i       (range_ok_i),
    .light_raw_i      (light_raw_i),
    .clear_alerts_i   (clear_alerts_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .tilt_alert_o     (tilt_alert_o),
    .near_alert_o     (near_alert_o),
    .tilt_crit_flag_o (tilt_crit_flag_o),
    .near_crit_flag_o (near_crit_flag_o),
    .shown_severity_o (shown_severity_o),
    .green_level_o    (green_level_o),
    .blue_level_o     (blue_level_o),
    .yellow_level_o   (yellow_level_o),
    .buzzer_sound_o   (buzzer_sound_o),
    .tone_hz_o        (tone_hz_o)
  );

  always #1 clk_i = ~clk_i;

  assign seen_readout = {tilt_alert_o, near_alert_o, tilt_crit_flag_o, near_crit_flag_o,
                         shown_severity_o, green_level_o, blue_level_o, yellow_level_o,
                         buzzer_sound_o, tone_hz_o};

  // Monitor: predict on each accepted sample beat, check each result beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_sample(timestamp_ms_i, tilt_tenths_i, range_tenths_i, range_ok_i,
                       light_raw_i, clear_alerts_i);
      if (out_valid_o && !out_stall_i)
        sb.check_readout(seen_readout);
    end
  end

  // Watchdog: too long without any beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("%0t: no beat for %0d cycles", $time, IdleLimit);
      $display("[posture_distance_alert_conditioner] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: long hold on request, else random stall bursts and free runs
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (!stall_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall_i <= 1'b0;
      free_left--;
    end else if ($urandom_range(2, 0) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(10, 0);
    end else begin
      out_stall_i <= 1'b0;
      free_left = $urandom_range(40, 0);
    end
  end

  // Offer one sample beat, optionally after a gap; valid stays high on return
  task automatic send_sample(logic [TsW-1:0] ts, logic [TiltW-1:0] tilt,
                             logic [RangeW-1:0] range, logic ok,
                             logic [LightW-1:0] light, logic clr);
    if (gaps_on && $urandom_range(5, 0) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(11, 1)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    timestamp_ms_i <= ts;
    tilt_tenths_i  <= tilt;
    range_tenths_i <= range;
    range_ok_i     <= ok;
    light_raw_i    <= light;
    clear_alerts_i <= clr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Drain all results, then rewrite every register
  task automatic load_settings(logic [CfgDataW-1:0] tw, tc, nw, nc, th, nh, st);
    in_valid_i <= 1'b0;
    while (sb.due_readouts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(REG_TILT_WARN, tw);
    write_reg(REG_TILT_CRITICAL, tc);
    write_reg(REG_NEAR_WARN, nw);
    write_reg(REG_NEAR_CRITICAL, nc);
    write_reg(REG_TILT_HOLD, th);
    write_reg(REG_NEAR_HOLD, nh);
    write_reg(REG_SETTLE, st);
    // the spare index has no register behind it
    write_reg(RegUnused, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic random_settings();
    logic [CfgDataW-1:0] tw, tc, nw, nc;
    tw = CfgDataW'($urandom_range(700, 0));
    tc = ($urandom_range(4, 0) == 0) ? CfgDataW'($urandom_range(1800, 0))
                                     : CfgDataW'(tw + $urandom_range(500, 0));
    nw = CfgDataW'($urandom_range(900, 0));
    nc = ($urandom_range(4, 0) == 0) ? CfgDataW'($urandom_range(4000, 0))
                                     : CfgDataW'($urandom_range(nw, 0));
    load_settings(tw, tc, nw, nc, CfgDataW'($urandom_range(2500, 0)),
                  CfgDataW'($urandom_range(2500, 0)), CfgDataW'($urandom_range(900, 0)));
  endtask

  // Episodes of upright, slouched, too close, both, or noise, with a
  // running millisecond clock so the hold and settle times come into play
  task automatic run_episodes(int unsigned n_items);
    int unsigned       sent, len, mode, k, pick, hi;
    logic [TiltW-1:0]  tilt;
    logic [RangeW-1:0] range;
    logic              ok, clr;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(4, 0);
      len  = $urandom_range(40, 5);
      for (k = 0; k < len && sent < n_items; k++) begin
        pick = $urandom_range(99, 0);
        if (pick < 3) clock_ms = $urandom;
        else if (pick < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(400, 0);
        else if (pick < 10) clock_ms += $urandom_range(8000, 0);
        else clock_ms += $urandom_range(200, 0);

        // tilt: slouched in modes 1 and 3, upright otherwise
        if (mode == 1 || mode == 3) begin
          hi = (sb.tilt_warn > 1800) ? 2047 : 1800;
          tilt = TiltW'($urandom_range(hi, sb.tilt_warn));
        end else begin
          tilt = (sb.tilt_warn == 0) ? '0 : TiltW'($urandom_range(sb.tilt_warn - 1, 0));
        end
        // distance: too close in modes 2 and 3, far or invalid otherwise
        ok = 1'b1;
        if (mode == 2 || mode == 3) begin
          if ($urandom_range(2, 0) == 0)
            range = RangeW'($urandom_range((sb.near_warn < 120) ? sb.near_warn : 120, 0));
          else
            range = RangeW'($urandom_range(sb.near_warn, 0));
        end else if (sb.near_warn >= 4000 || $urandom_range(3, 0) == 0) begin
          ok = 1'b0;
          range = RangeW'($urandom_range(4095, 0));
        end else begin
          range = RangeW'($urandom_range(4000, sb.near_warn + 1));
        end
        // noise episodes, and stray samples breaking the others
        if (mode == 4 || $urandom_range(11, 0) == 0) begin
          tilt  = TiltW'($urandom_range(2047, 0));
          range = RangeW'($urandom_range(4095, 0));
          ok    = 1'($urandom_range(1, 0));
        end
        clr = ($urandom_range(39, 0) == 0);
        send_sample(clock_ms, tilt, range, ok, LightW'($urandom_range(1023, 0)), clr);
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned ph;
    sb = new();
    clock_ms = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset settings: both timers start at time zero
    send_sample(32'd0,    11'd2047, 12'd0,    1'b1, 10'd0,    1'b0);
    send_sample(32'd2999, 11'd2047, 12'd0,    1'b1, 10'd1023, 1'b0);
    send_sample(32'd3000, 11'd2047, 12'd0,    1'b1, 10'd1023, 1'b0);
    send_sample(32'd3100, 11'd1800, 12'd0,    1'b1, 10'd0,    1'b0);
    send_sample(32'd3250, 11'd1800, 12'd10,   1'b1, 10'd512,  1'b0);
    send_sample(32'd3400, 11'd1800, 12'd10,   1'b1, 10'd1023, 1'b0);
    send_sample(32'd3500, 11'd1800, 12'd10,   1'b1, 10'd1,    1'b0);
    send_sample(32'd3700, 11'd1800, 12'd10,   1'b1, 10'd700,  1'b0);
    // clear request while both alerts are up
    send_sample(32'd3800, 11'd2047, 12'd0,    1'b1, 10'd1023, 1'b1);
    send_sample(32'd6800, 11'd1800, 12'd4000, 1'b1, 10'd300,  1'b0);
    send_sample(32'd7000, 11'd400,  12'd4095, 1'b1, 10'd300,  1'b0);
    send_sample(32'd7500, 11'd400,  12'd50,   1'b0, 10'd900,  1'b0);
    send_sample(32'd7600, 11'd400,  12'd50,   1'b0, 10'd900,  1'b0);
    send_sample(32'd8000, 11'd0,    12'd100,  1'b1, 10'd200,  1'b0);
    send_sample(32'd11000, 11'd0,   12'd100,  1'b1, 10'd200,  1'b0);
    send_sample(32'd11100, 11'd0,   12'd50,   1'b1, 10'd200,  1'b0);
    send_sample(32'd11700, 11'd0,   12'd300,  1'b1, 10'd200,  1'b0);
    send_sample(32'd12800, 11'd0,   12'd300,  1'b1, 10'd200,  1'b0);
    // millisecond counter wrapping under a running timer
    send_sample(32'hFFFF_FF00, 11'd600, 12'd4000, 1'b1, 10'd1023, 1'b0);
    send_sample(32'h0000_0C00, 11'd600, 12'd4000, 1'b1, 10'd1023, 1'b0);
    send_sample(32'h0000_1000, 11'd600, 12'd4000, 1'b1, 10'd1023, 1'b0);
    send_sample(32'h0000_1400, 11'd600, 12'd4000, 1'b1, 10'd0,    1'b0);
    send_sample(32'h0000_1800, 11'd0,   12'd4000, 1'b0, 10'd0,    1'b0);
    clock_ms = 32'h0000_1800;

    // Zero thresholds and times: alerts rise at once
    load_settings('0, '0, '0, '0, '0, '0, '0);
    run_episodes(150);
    // All ones: above-range bits are cut to each register's width
    load_settings('1, '1, '1, '1, '1, '1, '1);
    run_episodes(150);

    for (ph = 0; ph < 8; ph++) begin
      stall_on = ($urandom_range(3, 0) != 0);
      gaps_on  = ($urandom_range(3, 0) != 0);
      random_settings();
      if (ph == 2) begin
        // long output hold while samples keep coming: input must stall
        gaps_on = 1'b0;
        hold_request = 1'b1;
        run_episodes(40);
        gaps_on = 1'b1;
        run_episodes(110);
      end else begin
        run_episodes(150);
      end
    end

    // Last stretch at full rate on both sides
    stall_on = 1'b0;
    gaps_on  = 1'b0;
    random_settings();
    run_episodes(100);

    in_valid_i <= 1'b0;
    while (sb.due_readouts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Checked %0d result beats over %0d register settings,", sb.checked, n_settings);
    $display("with random gaps, stall bursts and one long output hold.");
    if (sb.errors == 0 && sb.due_readouts.size() == 0) begin
      $display("[posture_distance_alert_conditioner] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.due_readouts.size());
      $display("[posture_distance_alert_conditioner] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pdac_pkg.sv
rtl/pdac_alert.sv
rtl/pdac_sev.sv
rtl/pdac_buzz.sv
rtl/posture_distance_alert_conditioner.sv
bench/posture_distance_alert_conditioner_test.sv
